/* rtl/core/sunrise_sunset_detector_assert.svh */
// assertion macros used by the checker file
`ifndef SUNRISE_SUNSET_DETECTOR_ASSERT_SVH
`define SUNRISE_SUNSET_DETECTOR_ASSERT_SVH

// same-cycle implication, quiet during reset
`define SSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define SSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ssd_pkg.sv */
package ssd_pkg;

  // block dimensions
  localparam int SENSOR_COUNT  = 4;
  localparam int HISTORY_DEPTH = 6;
  localparam int SENSOR_W      = 10;
  localparam int TIME_W        = 32;
  localparam int SLOT_W        = 3;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;

  // history addressing: both logs share one memory, sunrise log in the low half
  localparam int PTR_W      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W      = $clog2(HISTORY_DEPTH + 1);
  localparam int HIST_WORDS = 2 * HISTORY_DEPTH;
  localparam int HIST_AW    = $clog2(HIST_WORDS);
  localparam int IDX_W      = ((SLOT_W > HIST_AW) ? SLOT_W : HIST_AW) + 1;

  // reset values of the registers
  localparam logic [SENSOR_W-1:0] THRESHOLD_RESET = SENSOR_W'(100);
  localparam logic [TIME_W-1:0]   MIN_NIGHT_RESET = TIME_W'(10000);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_NIGHT = CFG_IDX_W'(1);

  // request and log codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_READ   = 1'b1;
  localparam logic KIND_RISE  = 1'b0;
  localparam logic KIND_SET   = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [SENSOR_W-1:0] sensor_0;
    logic [SENSOR_W-1:0] sensor_1;
    logic [SENSOR_W-1:0] sensor_2;
    logic [SENSOR_W-1:0] sensor_3;
    logic [TIME_W-1:0]   now_ms;
    logic                history_kind;
    logic [SLOT_W-1:0]   history_slot;
  } ssd_in_t;

  typedef struct packed {
    logic              bright;
    logic              daytime;
    logic              sunrise_logged;
    logic              sunset_logged;
    logic [TIME_W-1:0] event_time;
    logic [TIME_W-1:0] read_time;
    logic              read_empty;
  } ssd_out_t;

endpackage

/* rtl/core/sunrise_sunset_detector.sv */
// Sunrise/sunset detector. Each accepted beat is either a sample (four photocell
// readings and a millisecond time) or a read of one history entry, and yields one
// result beat. The block takes one beat per clock unless the output stalls; a beat's
// result is first registered alongside the registered read of the history memory,
// then in the output register. Both six-entry histories live in one memory of
// twelve words used as two ring buffers, each with a write pointer and a fill count;
// samples write the memory and reads read it in the cycle of acceptance. Registers
// are written over the cfg channel, which is always ready: index 0 is the light
// threshold, index 1 the minimum night length; other indexes are ignored.
module sunrise_sunset_detector
  import ssd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ssd_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ssd_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // registers and detector state
  logic [SENSOR_W-1:0] light_threshold;
  logic [TIME_W-1:0]   min_night_ms;
  logic                day_flag;
  logic                cand_valid;
  logic [TIME_W-1:0]   cand_time;
  logic [PTR_W-1:0]    rise_ptr;
  logic [PTR_W-1:0]    set_ptr;
  logic [CNT_W-1:0]    rise_fill;
  logic [CNT_W-1:0]    set_fill;

  // history memory
  logic [TIME_W-1:0]   hist_mem [HIST_WORDS];
  logic [TIME_W-1:0]   mem_q;

  // pipeline
  logic                s1_valid;
  ssd_out_t            s1;
  logic                s1_hit;

  // combinational
  logic [SENSOR_W-1:0] sensor_vec [4];
  logic                accept;
  logic                out_free;
  logic                is_sample;
  logic                bright;
  logic [TIME_W-1:0]   elapsed;
  logic                rise_push;
  logic                set_push;
  logic                cand_open;
  logic                cand_drop;
  logic                day_next;
  logic [PTR_W-1:0]    push_ptr;
  logic [HIST_AW-1:0]  wr_addr;
  logic [TIME_W-1:0]   wr_data;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    rd_fill;
  logic [IDX_W-1:0]    slot_x;
  logic [IDX_W-1:0]    rd_pos;
  logic [HIST_AW-1:0]  rd_addr;
  logic                rd_hit;
  ssd_out_t            s1_next;
  ssd_out_t            out_next;

  // handshakes
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = !s1_valid || out_free;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // light decision over the counted sensors
  assign sensor_vec[0] = in_data.sensor_0;
  assign sensor_vec[1] = in_data.sensor_1;
  assign sensor_vec[2] = in_data.sensor_2;
  assign sensor_vec[3] = in_data.sensor_3;

  always_comb begin
    bright = 1'b0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (sensor_vec[i] > light_threshold) begin
        bright = 1'b1;
      end
    end
  end

  // day/night transitions
  assign is_sample = (in_data.req_type == REQ_SAMPLE);
  assign elapsed   = in_data.now_ms - cand_time;
  assign rise_push = is_sample && bright && !day_flag;
  assign cand_open = is_sample && !bright && day_flag && !cand_valid;
  assign set_push  = is_sample && !bright && day_flag && cand_valid &&
                     (elapsed >= min_night_ms);
  assign cand_drop = is_sample && bright && day_flag;
  assign day_next  = rise_push ? 1'b1 : (set_push ? 1'b0 : day_flag);

  // history write port
  assign push_ptr = rise_push ? rise_ptr : set_ptr;
  assign wr_addr  = set_push ? HIST_AW'(push_ptr) + HIST_AW'(HISTORY_DEPTH)
                             : HIST_AW'(push_ptr);
  assign wr_data  = rise_push ? in_data.now_ms : cand_time;

  // history read address: slot 0 is the oldest entry, at the write pointer
  always_comb begin
    rd_ptr  = (in_data.history_kind == KIND_SET) ? set_ptr : rise_ptr;
    rd_fill = (in_data.history_kind == KIND_SET) ? set_fill : rise_fill;
    slot_x  = IDX_W'(in_data.history_slot);
    rd_pos  = IDX_W'(rd_ptr) + slot_x;
    if (rd_pos >= IDX_W'(HISTORY_DEPTH)) begin
      rd_pos = rd_pos - IDX_W'(HISTORY_DEPTH);
    end
    rd_addr = (in_data.history_kind == KIND_SET)
              ? HIST_AW'(rd_pos) + HIST_AW'(HISTORY_DEPTH)
              : HIST_AW'(rd_pos);
    rd_hit  = (slot_x < IDX_W'(HISTORY_DEPTH)) &&
              (slot_x + IDX_W'(rd_fill) >= IDX_W'(HISTORY_DEPTH));
  end

  // result fields known at acceptance
  always_comb begin
    s1_next                = '0;
    s1_next.bright         = is_sample && bright;
    s1_next.daytime        = day_next;
    s1_next.sunrise_logged = rise_push;
    s1_next.sunset_logged  = set_push;
    s1_next.event_time     = rise_push ? in_data.now_ms : (set_push ? cand_time : '0);
    s1_next.read_empty     = !is_sample && !rd_hit;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      light_threshold <= THRESHOLD_RESET;
      min_night_ms    <= MIN_NIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_THRESHOLD: light_threshold <= cfg_data[SENSOR_W-1:0];
        CFG_MIN_NIGHT: min_night_ms    <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // day flag, sunset candidate, ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      day_flag   <= 1'b0;
      cand_valid <= 1'b0;
      cand_time  <= '0;
      rise_ptr   <= '0;
      set_ptr    <= '0;
      rise_fill  <= '0;
      set_fill   <= '0;
    end else if (accept) begin
      day_flag <= day_next;
      if (cand_open) begin
        cand_valid <= 1'b1;
        cand_time  <= in_data.now_ms;
      end else if (set_push || cand_drop) begin
        cand_valid <= 1'b0;
        cand_time  <= '0;
      end
      if (rise_push) begin
        rise_ptr <= (rise_ptr == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : rise_ptr + 1'b1;
        if (rise_fill != CNT_W'(HISTORY_DEPTH)) begin
          rise_fill <= rise_fill + 1'b1;
        end
      end
      if (set_push) begin
        set_ptr <= (set_ptr == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : set_ptr + 1'b1;
        if (set_fill != CNT_W'(HISTORY_DEPTH)) begin
          set_fill <= set_fill + 1'b1;
        end
      end
    end
  end

  // history memory, one write or one registered read per beat
  always_ff @(posedge clk) begin
    if (accept && (rise_push || set_push)) begin
      hist_mem[wr_addr] <= wr_data;
    end
    if (accept && (in_data.req_type == REQ_READ) && rd_hit) begin
      mem_q <= hist_mem[rd_addr];
    end
  end

  // stage waiting on read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1     <= s1_next;
      s1_hit <= !is_sample && rd_hit;
    end
  end

  // merge read data into the result
  always_comb begin
    out_next           = s1;
    out_next.read_time = s1_hit ? mem_q : '0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && out_free) begin
      out_data <= out_next;
    end
  end

endmodule

/* rtl/core/ssd_checker.sv */
`include "sunrise_sunset_detector_assert.svh"

module ssd_checker
  import ssd_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input ssd_out_t out_data
);

  // a stalled result beat holds
  `SSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")

  // light always ends in day
  `SSD_ASSERT_NOW(a_bright_day, out_valid && out_data.bright, out_data.daytime && !out_data.sunset_logged, "bright result without day")

  // a sunset comes from a dark sample and leaves night
  `SSD_ASSERT_NOW(a_sunset_night, out_valid && out_data.sunset_logged, !out_data.daytime && !out_data.sunrise_logged && !out_data.read_empty, "sunset result inconsistent")

  // an empty read carries no time and no event
  `SSD_ASSERT_NOW(a_empty_read, out_valid && out_data.read_empty, out_data.read_time == '0 && out_data.event_time == '0 && !out_data.bright, "empty read carries data")

  // a full output with no taker blocks new beats only through the pipeline
  `SSD_ASSERT_NOW(a_ready_free, !out_valid, in_ready, "input stalled with output empty")

endmodule

bind sunrise_sunset_detector ssd_checker u_ssd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* tb/sv/tb_top.sv */
module tb_top;
  import ssd_pkg::*;

  // index outside the register map, the block must ignore it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  ssd_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  ssd_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  sunrise_sunset_detector dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit, several times the slowest legal run
  initial begin
    #1000000;
    $display("CHECKS FAILED");
    $finish;
  end

  ssd_in_t     pending_reqs[$];
  ssd_out_t    expected_results[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  bit          in_fire = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  bit          calm_in = 1'b0;
  bit          calm_out = 1'b0;

  // predicted sky state and register copies
  logic [SENSOR_W-1:0] sky_thr;
  logic [TIME_W-1:0]   sky_min_night;
  logic                sky_day;
  logic                cand_open;
  logic [TIME_W-1:0]   cand_at;
  logic [TIME_W-1:0]   rise_at [HISTORY_DEPTH];
  logic                rise_ok [HISTORY_DEPTH];
  logic [TIME_W-1:0]   set_at  [HISTORY_DEPTH];
  logic                set_ok  [HISTORY_DEPTH];

  // stimulus generator state
  logic [SENSOR_W-1:0] gen_thr = THRESHOLD_RESET;
  logic [TIME_W-1:0]   gen_min = MIN_NIGHT_RESET;
  logic [TIME_W-1:0]   cursor_ms;
  bit                  want_light = 1'b0;

  task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                 input logic [TIME_W-1:0] want);
    $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  // push one timestamp into a history, oldest entry falls out
  task automatic log_event(input logic kind, input logic [TIME_W-1:0] stamp);
    for (int i = 0; i + 1 < HISTORY_DEPTH; i++) begin
      if (kind == KIND_SET) begin
        set_at[i] = set_at[i + 1];
        set_ok[i] = set_ok[i + 1];
      end else begin
        rise_at[i] = rise_at[i + 1];
        rise_ok[i] = rise_ok[i + 1];
      end
    end
    if (kind == KIND_SET) begin
      set_at[HISTORY_DEPTH - 1] = stamp;
      set_ok[HISTORY_DEPTH - 1] = 1'b1;
    end else begin
      rise_at[HISTORY_DEPTH - 1] = stamp;
      rise_ok[HISTORY_DEPTH - 1] = 1'b1;
    end
  endtask

  // advance the predicted sky state by one request and form its result
  task automatic sky_step(input ssd_in_t req, output ssd_out_t res);
    logic              lit;
    logic              hit;
    logic [TIME_W-1:0] dark_for;
    res = '0;
    if (req.req_type == REQ_SAMPLE) begin
      lit = (req.sensor_0 > sky_thr) || (req.sensor_1 > sky_thr) ||
            (req.sensor_2 > sky_thr) || (req.sensor_3 > sky_thr);
      dark_for = req.now_ms - cand_at;
      if (lit && !sky_day) begin
        log_event(KIND_RISE, req.now_ms);
        sky_day = 1'b1;
        res.sunrise_logged = 1'b1;
        res.event_time = req.now_ms;
      end else if (!lit && sky_day) begin
        // first dark sample only opens the candidate
        if (!cand_open) begin
          cand_open = 1'b1;
          cand_at = req.now_ms;
        end else if (dark_for >= sky_min_night) begin
          log_event(KIND_SET, cand_at);
          res.sunset_logged = 1'b1;
          res.event_time = cand_at;
          cand_open = 1'b0;
          cand_at = '0;
          sky_day = 1'b0;
        end
      end else if (lit && sky_day) begin
        cand_open = 1'b0;
        cand_at = '0;
      end
      res.bright = lit;
    end else begin
      if (req.history_slot < HISTORY_DEPTH) begin
        hit = (req.history_kind == KIND_SET) ? set_ok[req.history_slot]
                                             : rise_ok[req.history_slot];
        if (hit)
          res.read_time = (req.history_kind == KIND_SET) ? set_at[req.history_slot]
                                                         : rise_at[req.history_slot];
        else
          res.read_empty = 1'b1;
      end else begin
        res.read_empty = 1'b1;
      end
    end
    res.daytime = sky_day;
  endtask

  // monitor: config and request beats feed the prediction, result beats are checked
  always @(posedge clk) begin : watch
    ssd_out_t want;
    if (rst) begin
      sky_thr = THRESHOLD_RESET;
      sky_min_night = MIN_NIGHT_RESET;
      sky_day = 1'b0;
      cand_open = 1'b0;
      cand_at = '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        rise_at[i] = '0;
        rise_ok[i] = 1'b0;
        set_at[i] = '0;
        set_ok[i] = 1'b0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THRESHOLD: sky_thr = cfg_data[SENSOR_W-1:0];
          CFG_MIN_NIGHT: sky_min_night = cfg_data[TIME_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        sky_step(in_data, want);
        expected_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected", '0, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.bright !== want.bright)
            report_mismatch("bright", TIME_W'(out_data.bright), TIME_W'(want.bright));
          if (out_data.daytime !== want.daytime)
            report_mismatch("daytime", TIME_W'(out_data.daytime), TIME_W'(want.daytime));
          if (out_data.sunrise_logged !== want.sunrise_logged)
            report_mismatch("sunrise_logged", TIME_W'(out_data.sunrise_logged),
                            TIME_W'(want.sunrise_logged));
          if (out_data.sunset_logged !== want.sunset_logged)
            report_mismatch("sunset_logged", TIME_W'(out_data.sunset_logged),
                            TIME_W'(want.sunset_logged));
          if (out_data.event_time !== want.event_time)
            report_mismatch("event_time", out_data.event_time, want.event_time);
          if (out_data.read_time !== want.read_time)
            report_mismatch("read_time", out_data.read_time, want.read_time);
          if (out_data.read_empty !== want.read_empty)
            report_mismatch("read_empty", TIME_W'(out_data.read_empty),
                            TIME_W'(want.read_empty));
        end
        results_seen++;
      end
    end
    in_fire = !rst && in_valid && in_ready;
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 40);
  endfunction

  // request driver, one beat per accepted item
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // hold the beat until taken
    end else if (in_gap != 0) begin
      in_gap--;
      in_valid <= 1'b0;
    end else if (pending_reqs.size() != 0) begin
      in_data <= pending_reqs.pop_front();
      in_valid <= 1'b1;
      in_gap = calm_in ? 0 : pick_gap();
      if ($urandom_range(0, 63) == 0)
        calm_in = !calm_in;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (out_hold != 0) begin
      out_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm_out && $urandom_range(0, 99) < 25)
        out_hold = pick_gap();
    end
    if ($urandom_range(0, 255) == 0)
      calm_out = !calm_out;
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // new light settings, upper threshold bits carry junk
  task automatic set_sky(input logic [SENSOR_W-1:0] thr, input logic [TIME_W-1:0] min_ms);
    logic [CFG_DATA_W-1:0] word;
    wait_drained();
    word = $urandom;
    word[SENSOR_W-1:0] = thr;
    gen_thr = thr;
    gen_min = min_ms;
    write_reg(CFG_THRESHOLD, word);
    write_reg(CFG_MIN_NIGHT, min_ms);
  endtask

  task automatic push_sample(input logic [SENSOR_W-1:0] s0, s1, s2, s3,
                             input logic [TIME_W-1:0] at);
    ssd_in_t r;
    r = '0;
    r.req_type = REQ_SAMPLE;
    r.sensor_0 = s0;
    r.sensor_1 = s1;
    r.sensor_2 = s2;
    r.sensor_3 = s3;
    r.now_ms = at;
    r.history_kind = 1'($urandom_range(0, 1));
    r.history_slot = SLOT_W'($urandom_range(0, 7));
    pending_reqs.push_back(r);
  endtask

  task automatic push_read(input logic kind, input logic [SLOT_W-1:0] slot);
    ssd_in_t r;
    r.req_type = REQ_READ;
    r.sensor_0 = SENSOR_W'($urandom_range(0, 1023));
    r.sensor_1 = SENSOR_W'($urandom_range(0, 1023));
    r.sensor_2 = SENSOR_W'($urandom_range(0, 1023));
    r.sensor_3 = SENSOR_W'($urandom_range(0, 1023));
    r.now_ms = $urandom;
    r.history_kind = kind;
    r.history_slot = slot;
    pending_reqs.push_back(r);
  endtask

  // time advance, scaled to the night length with some boundary and wrap steps
  function automatic logic [TIME_W-1:0] pick_step(input logic [TIME_W-1:0] min_ms);
    logic [TIME_W-1:0] span;
    span = (min_ms == 0) ? 20 : (min_ms > 100000) ? 100000 : min_ms;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 2 * span);
      5: return min_ms - 1;
      6: return min_ms + $urandom_range(0, 2);
      7: return '1;
      8: return $urandom;
      default: return '0;
    endcase
  endfunction

  // mostly day/night runs with plausible readings, some noise and reads
  task automatic run_random(input int unsigned count);
    logic [SENSOR_W-1:0] s [4];
    int unsigned         k;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 25) begin
        push_read(1'($urandom_range(0, 1)),
                  SLOT_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 5)
                                                       : $urandom_range(6, 7)));
      end else begin
        if ($urandom_range(0, 99) < 30)
          want_light = !want_light;
        cursor_ms = cursor_ms + pick_step(gen_min);
        for (int i = 0; i < 4; i++)
          s[i] = SENSOR_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                       : $urandom_range(0, gen_thr));
        if (want_light && gen_thr != 1023) begin
          k = $urandom_range(0, 3);
          s[k] = SENSOR_W'($urandom_range(gen_thr + 1, 1023));
        end
        push_sample(s[0], s[1], s[2], s[3], cursor_ms);
      end
    end
  endtask

  initial begin
    cursor_ms = $urandom;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty histories, including slots past the depth
    push_read(KIND_RISE, 0);
    push_read(KIND_SET, 5);
    push_read(KIND_RISE, 6);
    push_read(KIND_SET, 7);
    // at threshold is dark; dark at night changes nothing
    push_sample(100, 100, 100, 100, 5);
    push_sample(0, 0, 0, 101, 1000);
    push_sample(1023, 0, 0, 0, 1500);
    // candidate opened, then dropped by light
    push_sample(0, 0, 0, 0, 2000);
    push_sample(0, 101, 0, 0, 3000);
    // one short of the night length, then exactly enough
    push_sample(0, 0, 0, 0, 4000);
    push_sample(0, 0, 100, 0, 13999);
    push_sample(0, 0, 0, 0, 14000);
    push_read(KIND_RISE, 5);
    push_read(KIND_SET, 5);
    push_read(KIND_SET, 4);
    // night length measured across the time wrap
    push_sample(0, 0, 1023, 0, 32'hFFFF_FF00);
    push_sample(0, 0, 0, 0, 32'hFFFF_FFF0);
    push_sample(0, 0, 0, 0, 32'h0000_2800);
    push_read(KIND_SET, 5);

    // zero night length: opening sample still does not confirm
    set_sky(0, 0);
    push_sample(1, 0, 0, 0, 50);
    push_sample(0, 0, 0, 0, 60);
    push_sample(0, 0, 0, 0, 60);
    run_random(200);

    set_sky(1023, 32'hFFFF_FFFF);
    run_random(200);

    set_sky(512, 50);
    write_reg(CFG_SPARE, $urandom);
    run_random(250);

    set_sky(THRESHOLD_RESET, MIN_NIGHT_RESET);
    run_random(250);

    set_sky(SENSOR_W'($urandom_range(1, 1022)), $urandom_range(1, 3000));
    run_random(300);

    set_sky(1, 1);
    run_random(250);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
